/* rtl/assert_macros.svh */
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication checked every clock outside reset
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

/* rtl/mhpq_pkg.sv */
// package for the max heap priority queue
// types, constants and state codes used by the rtl modules
package mhpq_pkg;
	localparam int CAPACITY = 1024;
	localparam int MAX_K = 64;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = AW + 1;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_EXTRACT = 2'd1;
	localparam logic [1:0] ACT_TOPK = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [15:0] key;
		logic [15:0] item;
		logic [6:0] top_count;
	} in_t;

	typedef struct packed {
		logic [15:0] out_key;
		logic [15:0] out_item;
		logic [1:0] status;
		logic [10:0] entry_count;
		logic last;
	} out_t;

	typedef struct packed {
		logic [15:0] key;
		logic [15:0] item;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD,
		S_DN_WAIT,
		S_DN_CMP,
		S_CP_RD,
		S_CP_WR,
		S_EMIT,
		S_ROOT_RD,
		S_ROOT_WAIT
	} state_t;

	typedef struct packed {
		logic re;
		logic [AW-1:0] raddr;
		logic we;
		logic [AW-1:0] waddr;
		entry_t wdata;
	} mem_req_t;
endpackage

/* rtl/mhpq_ram.sv */
// single write, single read port entry memory with registered read
// depends on mhpq_pkg
module mhpq_ram (
	input logic clk,
	input mhpq_pkg::mem_req_t req,
	output mhpq_pkg::entry_t rdata
);
	mhpq_pkg::entry_t mem [mhpq_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end
endmodule

/* rtl/max_heap_priority_queue.sv */
// max heap priority queue of (key, item) entries with insert, extract,
// top-k listing and clear; one memory port pair per store, shared comparator
// depends on mhpq_pkg, mhpq_ram and assert_macros.svh
//
// usage: drive cmd and raise start while busy is low; the transaction is
// taken at that edge. results appear on rsp with rsp_valid high for exactly
// one cycle each; rsp.last marks the final result of a transaction. the
// receiver cannot stall, so results are never held.
// insert, extract and top-k raise busy the cycle after the accepting edge.
// insert climbs the heap a level at a time, reading the parent and then
// comparing it with the new entry; extract descends a level at a time
// (each level reads one entry at a time from the single read port and
// compares in one shared key comparator).
// top-k first copies the heap into the scratch store entry by entry,
// then for each of k results runs an extract on the copy. clear and every
// error case answer in the cycle after the accepting edge and never raise
// busy. reset clears the entry count and state; store contents are kept and
// never read above the count.
`include "assert_macros.svh"
module max_heap_priority_queue (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input mhpq_pkg::in_t cmd,
	output logic rsp_valid,
	output mhpq_pkg::out_t rsp
);
	localparam int AW = mhpq_pkg::AW;
	localparam int CW = mhpq_pkg::CW;

	mhpq_pkg::state_t state_q, state_d;
	logic [CW-1:0] fill_q, fill_d;
	logic [CW-1:0] n_q, n_d;
	logic [AW-1:0] pos_q, pos_d;
	logic [AW-1:0] big_q, big_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [6:0] left_q, left_d;
	logic sel_q, sel_d;
	logic topk_q, topk_d;
	logic phase_q, phase_d;
	mhpq_pkg::entry_t cur_q, cur_d;
	mhpq_pkg::entry_t bige_q, bige_d;
	mhpq_pkg::entry_t top_q, top_d;
	mhpq_pkg::entry_t new_q, new_d;
	logic rv_d;
	mhpq_pkg::out_t rsp_d;
	mhpq_pkg::mem_req_t hreq, sreq;
	mhpq_pkg::entry_t hdata, sdata, rd;
	logic gt;
	logic [15:0] ca, cb;
	logic [CW:0] lft;
	logic [6:0] kin;

	mhpq_ram u_heap (.clk(clk), .req(hreq), .rdata(hdata));
	mhpq_ram u_scratch (.clk(clk), .req(sreq), .rdata(sdata));

	assign rd = sel_q ? sdata : hdata;
	assign gt = ca > cb;
	assign busy = state_q != mhpq_pkg::S_IDLE;
	assign kin = (cmd.top_count > 7'(mhpq_pkg::MAX_K)) ? 7'(mhpq_pkg::MAX_K) : cmd.top_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mhpq_pkg::S_IDLE;
			fill_q <= '0;
			rsp_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q <= fill_d;
			rsp_valid <= rv_d;
		end
	end

	always_ff @(posedge clk) begin
		n_q <= n_d;
		pos_q <= pos_d;
		big_q <= big_d;
		idx_q <= idx_d;
		left_q <= left_d;
		sel_q <= sel_d;
		topk_q <= topk_d;
		phase_q <= phase_d;
		cur_q <= cur_d;
		bige_q <= bige_d;
		top_q <= top_d;
		new_q <= new_d;
		rsp <= rsp_d;
	end

	always_comb begin
		mhpq_pkg::mem_req_t req;
		state_d = state_q;
		fill_d = fill_q;
		n_d = n_q;
		pos_d = pos_q;
		big_d = big_q;
		idx_d = idx_q;
		left_d = left_q;
		sel_d = sel_q;
		topk_d = topk_q;
		phase_d = phase_q;
		cur_d = cur_q;
		bige_d = bige_q;
		top_d = top_q;
		new_d = new_q;
		rv_d = 1'b0;
		rsp_d = rsp;
		req = '0;
		hreq = '0;
		sreq = '0;
		ca = rd.key;
		cb = bige_q.key;
		lft = {1'b0, pos_q, 1'b1};
		case (state_q)
			mhpq_pkg::S_IDLE: begin
				if (start) begin
					rsp_d = '0;
					rsp_d.last = 1'b1;
					rsp_d.entry_count = 11'(fill_q);
					case (cmd.action)
						mhpq_pkg::ACT_INSERT: begin
							if (fill_q >= CW'(mhpq_pkg::CAPACITY)) begin
								rsp_d.status = mhpq_pkg::ST_FULL;
								rv_d = 1'b1;
							end else begin
								new_d = '{key: cmd.key, item: cmd.item};
								pos_d = AW'(fill_q);
								sel_d = 1'b0;
								state_d = mhpq_pkg::S_UP_RD;
							end
						end
						mhpq_pkg::ACT_EXTRACT: begin
							if (fill_q == '0) begin
								rsp_d.status = mhpq_pkg::ST_EMPTY;
								rv_d = 1'b1;
							end else begin
								sel_d = 1'b0;
								topk_d = 1'b0;
								n_d = fill_q - CW'(1);
								hreq.re = 1'b1;
								hreq.raddr = '0;
								phase_d = 1'b0;
								state_d = mhpq_pkg::S_ROOT_RD;
							end
						end
						mhpq_pkg::ACT_TOPK: begin
							if (kin == '0 || fill_q == '0) begin
								rsp_d.status = mhpq_pkg::ST_EMPTY;
								rv_d = 1'b1;
							end else begin
								left_d = (CW'(kin) < fill_q) ? kin : 7'(fill_q);
								topk_d = 1'b1;
								idx_d = '0;
								sel_d = 1'b0;
								state_d = mhpq_pkg::S_CP_RD;
							end
						end
						default: begin
							fill_d = '0;
							rsp_d.entry_count = '0;
							rv_d = 1'b1;
						end
					endcase
				end
			end
			mhpq_pkg::S_UP_RD: begin
				if (pos_q == '0) begin
					hreq.we = 1'b1;
					hreq.waddr = '0;
					hreq.wdata = new_q;
					fill_d = fill_q + CW'(1);
					rsp_d.entry_count = 11'(fill_q + CW'(1));
					rv_d = 1'b1;
					state_d = mhpq_pkg::S_IDLE;
				end else begin
					hreq.re = 1'b1;
					hreq.raddr = (pos_q - AW'(1)) >> 1;
					state_d = mhpq_pkg::S_UP_CMP;
				end
			end
			mhpq_pkg::S_UP_CMP: begin
				ca = new_q.key;
				cb = rd.key;
				hreq.we = 1'b1;
				hreq.waddr = pos_q;
				if (gt) begin
					hreq.wdata = rd;
					pos_d = (pos_q - AW'(1)) >> 1;
					state_d = mhpq_pkg::S_UP_RD;
				end else begin
					hreq.wdata = new_q;
					fill_d = fill_q + CW'(1);
					rsp_d.entry_count = 11'(fill_q + CW'(1));
					rv_d = 1'b1;
					state_d = mhpq_pkg::S_IDLE;
				end
			end
			mhpq_pkg::S_ROOT_WAIT: begin
				// root read once the last copied entry is written
				req.re = 1'b1;
				req.raddr = '0;
				state_d = mhpq_pkg::S_ROOT_RD;
			end
			mhpq_pkg::S_ROOT_RD: begin
				// phase 0: root data arrives; read last entry
				req.re = 1'b1;
				req.raddr = AW'(n_q);
				if (!phase_q) begin
					top_d = rd;
					phase_d = 1'b1;
				end else begin
					req.re = 1'b0;
					cur_d = rd;
					pos_d = '0;
					state_d = mhpq_pkg::S_DN_RD;
				end
				if (phase_q) begin
					state_d = (n_q == '0) ? mhpq_pkg::S_EMIT : mhpq_pkg::S_DN_RD;
				end else begin
					state_d = mhpq_pkg::S_ROOT_RD;
				end
			end
			mhpq_pkg::S_DN_RD: begin
				// left child read, big starts as the moving entry
				bige_d = cur_q;
				big_d = pos_q;
				phase_d = 1'b0;
				if (lft < {1'b0, n_q}) begin
					req.re = 1'b1;
					req.raddr = AW'(lft);
					state_d = mhpq_pkg::S_DN_WAIT;
				end else begin
					req.we = 1'b1;
					req.waddr = pos_q;
					req.wdata = cur_q;
					state_d = mhpq_pkg::S_EMIT;
				end
			end
			mhpq_pkg::S_DN_WAIT: begin
				// compare left child, issue right child read
				if (gt) begin
					bige_d = rd;
					big_d = AW'(lft);
				end
				if (lft + (CW+1)'(1) < {1'b0, n_q}) begin
					req.re = 1'b1;
					req.raddr = AW'(lft + (CW+1)'(1));
					state_d = mhpq_pkg::S_DN_CMP;
				end else begin
					phase_d = 1'b1;
					state_d = mhpq_pkg::S_DN_CMP;
				end
			end
			mhpq_pkg::S_DN_CMP: begin
				if (!phase_q && gt) begin
					bige_d = rd;
					big_d = AW'(lft + (CW+1)'(1));
				end else begin
					bige_d = bige_q;
					big_d = big_q;
				end
				req.we = 1'b1;
				req.waddr = pos_q;
				if (big_d == pos_q) begin
					req.wdata = cur_q;
					state_d = mhpq_pkg::S_EMIT;
				end else begin
					req.wdata = bige_d;
					pos_d = big_d;
					state_d = mhpq_pkg::S_DN_RD;
				end
			end
			mhpq_pkg::S_EMIT: begin
				rsp_d.out_key = top_q.key;
				rsp_d.out_item = top_q.item;
				rsp_d.status = mhpq_pkg::ST_OK;
				rv_d = 1'b1;
				if (!topk_q) begin
					fill_d = n_q;
					rsp_d.entry_count = 11'(n_q);
					rsp_d.last = 1'b1;
					state_d = mhpq_pkg::S_IDLE;
				end else begin
					rsp_d.entry_count = 11'(fill_q);
					rsp_d.last = left_q == 7'd1;
					left_d = left_q - 7'd1;
					if (left_q == 7'd1) begin
						state_d = mhpq_pkg::S_IDLE;
					end else begin
						n_d = n_q - CW'(1);
						req.re = 1'b1;
						req.raddr = '0;
						phase_d = 1'b0;
						state_d = mhpq_pkg::S_ROOT_RD;
					end
				end
			end
			mhpq_pkg::S_CP_RD: begin
				hreq.re = 1'b1;
				hreq.raddr = AW'(idx_q);
				state_d = mhpq_pkg::S_CP_WR;
			end
			mhpq_pkg::S_CP_WR: begin
				sreq.we = 1'b1;
				sreq.waddr = AW'(idx_q);
				sreq.wdata = hdata;
				idx_d = idx_q + CW'(1);
				if (idx_q + CW'(1) == fill_q) begin
					sel_d = 1'b1;
					n_d = fill_q - CW'(1);
					phase_d = 1'b0;
					state_d = mhpq_pkg::S_ROOT_WAIT;
				end else begin
					state_d = mhpq_pkg::S_CP_RD;
				end
			end
			default: begin
				state_d = mhpq_pkg::S_IDLE;
			end
		endcase
		if (state_q != mhpq_pkg::S_CP_WR && state_q != mhpq_pkg::S_UP_RD &&
			state_q != mhpq_pkg::S_UP_CMP && state_q != mhpq_pkg::S_IDLE &&
			state_q != mhpq_pkg::S_CP_RD) begin
			if (sel_q) begin
				sreq = req;
			end else begin
				hreq = req;
			end
		end
	end

	`ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= CW'(mhpq_pkg::CAPACITY))
	`ASSERT_IMPL(a_no_rsp_idle_start, rsp_valid && !rsp.last, busy)
	`ASSERT_NEXT(a_start_busy, start && !busy && !rv_d, busy)
	`ASSERT_IMPL(a_single_write, hreq.we && sreq.we, 1'b0)
endmodule

/* bench/tb_top.sv */
// testbench for max_heap_priority_queue: directed and random transactions
// checked against a behavioral max-heap predictor with a scoreboard queue
// depends on mhpq_pkg and the max_heap_priority_queue rtl
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	mhpq_pkg::in_t cmd = '0;
	logic rsp_valid;
	mhpq_pkg::out_t rsp;

	mhpq_pkg::entry_t heap_model[mhpq_pkg::CAPACITY];
	mhpq_pkg::entry_t heap_copy[mhpq_pkg::CAPACITY];
	int unsigned held = 0;
	mhpq_pkg::out_t expected_rsp[$];
	int errors = 0;
	int unsigned cycles = 0;
	int unsigned sent = 0;
	int unsigned received = 0;
	int unsigned topk_sent = 0;

	always #5 clk = ~clk;

	max_heap_priority_queue dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .rsp_valid(rsp_valid), .rsp(rsp)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("cycle limit reached");
			$display("FAIL max_heap_priority_queue");
			$finish;
		end
	end

	function automatic mhpq_pkg::out_t mk(logic [15:0] k, logic [15:0] it, logic [1:0] st,
		int unsigned n, logic lst);
		mhpq_pkg::out_t r;
		r.out_key = k;
		r.out_item = it;
		r.status = st;
		r.entry_count = 11'(n);
		r.last = lst;
		return r;
	endfunction

	function automatic void expect_rsp(mhpq_pkg::out_t r);
		expected_rsp = {expected_rsp, r};
	endfunction

	function automatic void sift_down_model(ref mhpq_pkg::entry_t a[mhpq_pkg::CAPACITY],
		input int unsigned n);
		int unsigned pos;
		int unsigned l;
		int unsigned big;
		mhpq_pkg::entry_t t;
		pos = 0;
		forever begin
			l = 2 * pos + 1;
			big = pos;
			if (l < n && a[l].key > a[big].key) big = l;
			if (l + 1 < n && a[l + 1].key > a[big].key) big = l + 1;
			if (big == pos) break;
			t = a[pos];
			a[pos] = a[big];
			a[big] = t;
			pos = big;
		end
	endfunction

	function automatic mhpq_pkg::entry_t pop_model(ref mhpq_pkg::entry_t a[mhpq_pkg::CAPACITY],
		ref int unsigned n);
		mhpq_pkg::entry_t top;
		top = a[0];
		n--;
		a[0] = a[n];
		if (n > 0) sift_down_model(a, n);
		return top;
	endfunction

	function automatic void predict_heap(mhpq_pkg::in_t c);
		int unsigned pos;
		int unsigned up;
		int unsigned k;
		int unsigned lim;
		int unsigned n;
		mhpq_pkg::entry_t t;
		case (c.action)
			mhpq_pkg::ACT_INSERT: begin
				if (held >= mhpq_pkg::CAPACITY) begin
					expect_rsp(mk(16'd0, 16'd0, mhpq_pkg::ST_FULL, held, 1'b1));
				end else begin
					heap_model[held] = '{key: c.key, item: c.item};
					pos = held;
					while (pos > 0) begin
						up = (pos - 1) / 2;
						if (!(heap_model[up].key < heap_model[pos].key)) break;
						t = heap_model[up];
						heap_model[up] = heap_model[pos];
						heap_model[pos] = t;
						pos = up;
					end
					held++;
					expect_rsp(mk(16'd0, 16'd0, mhpq_pkg::ST_OK, held, 1'b1));
				end
			end
			mhpq_pkg::ACT_EXTRACT: begin
				if (held == 0) begin
					expect_rsp(mk(16'd0, 16'd0, mhpq_pkg::ST_EMPTY, 0, 1'b1));
				end else begin
					t = pop_model(heap_model, held);
					expect_rsp(mk(t.key, t.item, mhpq_pkg::ST_OK, held, 1'b1));
				end
			end
			mhpq_pkg::ACT_TOPK: begin
				k = c.top_count;
				if (k > mhpq_pkg::MAX_K) k = mhpq_pkg::MAX_K;
				if (k == 0 || held == 0) begin
					expect_rsp(mk(16'd0, 16'd0, mhpq_pkg::ST_EMPTY, held, 1'b1));
				end else begin
					for (int i = 0; i < held; i++) heap_copy[i] = heap_model[i];
					n = held;
					lim = (k < held) ? k : held;
					for (int i = 0; i < lim; i++) begin
						t = pop_model(heap_copy, n);
						expect_rsp(mk(t.key, t.item, mhpq_pkg::ST_OK, held,
							i + 1 == lim));
					end
				end
			end
			default: begin
				held = 0;
				expect_rsp(mk(16'd0, 16'd0, mhpq_pkg::ST_OK, 0, 1'b1));
			end
		endcase
	endfunction

	always @(posedge clk) begin
		mhpq_pkg::out_t e;
		if (arst_n && rsp_valid) begin
			received++;
			if (expected_rsp.size() == 0) begin
				$error("unexpected result key=%0d item=%0d", rsp.out_key, rsp.out_item);
				errors++;
			end else begin
				e = expected_rsp.pop_front();
				if (rsp.out_key !== e.out_key) begin
					$error("out_key exp %0d got %0d", e.out_key, rsp.out_key);
					errors++;
				end
				if (rsp.out_item !== e.out_item) begin
					$error("out_item exp %0d got %0d", e.out_item, rsp.out_item);
					errors++;
				end
				if (rsp.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, rsp.status);
					errors++;
				end
				if (rsp.entry_count !== e.entry_count) begin
					$error("entry_count exp %0d got %0d", e.entry_count, rsp.entry_count);
					errors++;
				end
				if (rsp.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, rsp.last);
					errors++;
				end
			end
		end
	end

	// a zero gap keeps start high so the next transaction follows directly
	task automatic random_gap();
		int unsigned g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) g = 0;
		if (g > 0) begin
			start <= 1'b0;
			cmd <= mhpq_pkg::in_t'(($bits(mhpq_pkg::in_t))'({$urandom, $urandom}));
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic send_cmd(logic [1:0] act, logic [15:0] k, logic [15:0] it,
		logic [6:0] cnt);
		mhpq_pkg::in_t c;
		c.action = act;
		c.key = k;
		c.item = it;
		c.top_count = cnt;
		while (busy) @(negedge clk);
		cmd <= c;
		start <= 1'b1;
		@(posedge clk);
		predict_heap(c);
		sent++;
		if (c.action == mhpq_pkg::ACT_TOPK) topk_sent++;
		@(negedge clk);
		random_gap();
	endtask

	task automatic drain();
		start <= 1'b0;
		cmd <= mhpq_pkg::in_t'(($bits(mhpq_pkg::in_t))'({$urandom, $urandom}));
		while (expected_rsp.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic test_empty_cases();
		send_cmd(mhpq_pkg::ACT_EXTRACT, 16'hffff, 16'hffff, 7'd0);
		send_cmd(mhpq_pkg::ACT_TOPK, 16'h0, 16'h0, 7'd5);
		send_cmd(mhpq_pkg::ACT_INSERT, 16'hffff, 16'h0000, 7'd127);
		send_cmd(mhpq_pkg::ACT_TOPK, 16'h0, 16'h0, 7'd0);
		send_cmd(mhpq_pkg::ACT_INSERT, 16'h0000, 16'hffff, 7'd0);
		send_cmd(mhpq_pkg::ACT_INSERT, 16'h8000, 16'h1234, 7'd0);
		send_cmd(mhpq_pkg::ACT_INSERT, 16'h8000, 16'h5678, 7'd0);
		send_cmd(mhpq_pkg::ACT_INSERT, 16'h7fff, 16'h00ff, 7'd0);
		send_cmd(mhpq_pkg::ACT_TOPK, 16'h0, 16'h0, 7'd127);
		send_cmd(mhpq_pkg::ACT_TOPK, 16'h0, 16'h0, 7'd2);
		send_cmd(mhpq_pkg::ACT_EXTRACT, 16'h0, 16'h0, 7'd0);
		send_cmd(mhpq_pkg::ACT_EXTRACT, 16'h0, 16'h0, 7'd0);
		send_cmd(mhpq_pkg::ACT_CLEAR, 16'hffff, 16'hffff, 7'd127);
		send_cmd(mhpq_pkg::ACT_EXTRACT, 16'h0, 16'h0, 7'd0);
		drain();
	endtask

	task automatic test_ties();
		for (int i = 0; i < 8; i++)
			send_cmd(mhpq_pkg::ACT_INSERT, 16'(50 + (i % 2)), 16'(i), 7'd0);
		send_cmd(mhpq_pkg::ACT_TOPK, 16'h0, 16'h0, 7'd64);
		send_cmd(mhpq_pkg::ACT_TOPK, 16'h0, 16'h0, 7'd65);
		repeat (3) send_cmd(mhpq_pkg::ACT_EXTRACT, 16'h0, 16'h0, 7'd0);
		send_cmd(mhpq_pkg::ACT_CLEAR, 16'h0, 16'h0, 7'd0);
		drain();
	endtask

	task automatic test_random_mix();
		int unsigned r;
		for (int i = 0; i < 92; i++) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				send_cmd(mhpq_pkg::ACT_INSERT, ($urandom_range(0, 3) == 0) ?
					16'($urandom_range(0, 7)) : 16'($urandom), 16'($urandom),
					7'($urandom));
			else if (r < 75)
				send_cmd(mhpq_pkg::ACT_EXTRACT, 16'($urandom), 16'($urandom),
					7'($urandom));
			else if (r < 97)
				send_cmd(mhpq_pkg::ACT_TOPK, 16'($urandom), 16'($urandom),
					($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) :
					7'($urandom_range(1, 12)));
			else
				send_cmd(mhpq_pkg::ACT_CLEAR, 16'($urandom), 16'($urandom),
					7'($urandom));
		end
		drain();
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_empty_cases();
		test_ties();
		test_random_mix();
		$display("covered %0d transactions (%0d top-k) and %0d results over empty, tie,",
			sent, topk_sent, received);
		$display("saturated count and random insert/extract/top-k/clear sequences");
		if (errors == 0 && expected_rsp.size() == 0) begin
			$display("PASS max_heap_priority_queue");
		end else begin
			$display("FAIL max_heap_priority_queue");
		end
		$finish;
	end
endmodule

/* sim.f */
+incdir+rtl
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/max_heap_priority_queue.sv
bench/tb_top.sv
